[hw/rtl/pac_pkg.sv]
// ----------------------------------------------------------------------------
// pac_pkg
// shared types and constants of the pixel alpha compositor: operation codes,
// request and result payloads, configuration register set
// ----------------------------------------------------------------------------
package pac_pkg;

  typedef enum logic [2:0] {
    OP_BLEND     = 3'd0,
    OP_COPY      = 3'd1,
    OP_INV_BLEND = 3'd2,
    OP_AVG_BLEND = 3'd3,
    OP_AVG_COPY  = 3'd4,
    OP_GLYPH     = 3'd5,
    OP_SWAP      = 3'd6
  } op_t;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_TEXT_COLOR = 2'd0;
  localparam logic [1:0] REG_SWAP_MATCH = 2'd1;
  localparam logic [1:0] REG_SWAP_NEW   = 2'd2;

  localparam logic [23:0] TEXT_COLOR_RST = 24'hFF_FFFF;
  localparam logic [7:0]  CH_MAX         = 8'hFF;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] src_pixel;
    logic [31:0] src_pixel_second;
    logic [31:0] dst_pixel;
    logic [7:0]  coverage;
  } req_t;

  typedef struct packed {
    logic [31:0] result_pixel;
    logic        changed;
  } rsp_t;

  typedef struct packed {
    logic [23:0] text_color;
    logic [31:0] swap_match_color;
    logic [31:0] swap_new_color;
  } cfg_t;

endpackage

[hw/rtl/pac_pipe.sv]
// ----------------------------------------------------------------------------
// pac_pipe
// three stage compositing pipeline: source select, channel products,
// divide by 255 and final select into the output register
// ----------------------------------------------------------------------------
module pac_pipe (
  input  logic          clk,
  input  logic          rst,
  input  pac_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  pac_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pac_pkg::rsp_t out_data
);

  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  function automatic logic [31:0] avg_px(input logic [31:0] p, input logic [31:0] q);
    return {avg8(p[31:24], q[31:24]), avg8(p[23:16], q[23:16]),
            avg8(p[15:8], q[15:8]), avg8(p[7:0], q[7:0])};
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  logic adv1, adv2, adv3;

  // stage 1: decode and source select
  logic        valid1;
  logic        blend1;
  logic        chg1;
  logic [31:0] src1;
  logic [31:0] dst1;
  logic        blend1_next;
  logic        chg1_next;
  logic [31:0] src1_next;

  // stage 2: products
  logic        valid2;
  logic        blend2;
  logic        chg2;
  logic [31:0] src2;
  logic [31:0] dst2;
  logic [15:0] sum2 [3];
  logic [15:0] sum2_next [3];

  // stage 3: output register
  logic        valid3;
  logic [31:0] res3;
  logic        chg3;
  logic [31:0] res3_next;

  assign adv3     = !valid3 || out_ready;
  assign adv2     = !valid2 || adv3;
  assign adv1     = !valid1 || adv2;
  assign in_ready = adv1;

  always_comb begin
    blend1_next = 1'b0;
    chg1_next   = 1'b1;
    src1_next   = in_data.src_pixel;
    case (in_data.operation)
      pac_pkg::OP_BLEND: begin
        blend1_next = 1'b1;
      end
      pac_pkg::OP_COPY: begin
        blend1_next = 1'b0;
      end
      pac_pkg::OP_INV_BLEND: begin
        blend1_next = 1'b1;
        src1_next   = in_data.src_pixel ^ 32'h00FF_FFFF;
      end
      pac_pkg::OP_AVG_BLEND: begin
        blend1_next = 1'b1;
        src1_next   = avg_px(in_data.src_pixel, in_data.src_pixel_second);
      end
      pac_pkg::OP_AVG_COPY: begin
        src1_next = avg_px(in_data.src_pixel, in_data.src_pixel_second);
      end
      pac_pkg::OP_GLYPH: begin
        if (in_data.coverage == 8'd0) begin
          chg1_next = 1'b0;
          src1_next = in_data.dst_pixel;
        end else begin
          blend1_next = 1'b1;
          src1_next   = {in_data.coverage, cfg.text_color};
        end
      end
      pac_pkg::OP_SWAP: begin
        if (in_data.dst_pixel == cfg.swap_match_color) begin
          src1_next = cfg.swap_new_color;
        end else begin
          chg1_next = 1'b0;
          src1_next = in_data.dst_pixel;
        end
      end
      default: begin
        chg1_next = 1'b0;
        src1_next = in_data.dst_pixel;
      end
    endcase
  end

  always_comb begin
    logic [7:0] a;
    logic [7:0] na;
    a  = src1[31:24];
    na = pac_pkg::CH_MAX - a;
    for (int c = 0; c < 3; c++) begin
      sum2_next[c] = {8'd0, src1[8*c +: 8]} * {8'd0, a}
                   + {8'd0, dst1[8*c +: 8]} * {8'd0, na};
    end
  end

  always_comb begin
    logic [7:0] a;
    a = src2[31:24];
    if (!blend2) begin
      res3_next = src2;
    end else if (a == 8'd0) begin
      res3_next = dst2;
    end else if (a == pac_pkg::CH_MAX) begin
      res3_next = src2;
    end else begin
      res3_next = {pac_pkg::CH_MAX, div255(sum2[2]), div255(sum2[1]), div255(sum2[0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (adv1) begin
        valid1 <= in_valid;
      end
      if (adv2) begin
        valid2 <= valid1;
      end
      if (adv3) begin
        valid3 <= valid2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      blend1 <= blend1_next;
      chg1   <= chg1_next;
      src1   <= src1_next;
      dst1   <= in_data.dst_pixel;
    end
    if (adv2) begin
      blend2 <= blend1;
      chg2   <= chg1;
      src2   <= src1;
      dst2   <= dst1;
      sum2   <= sum2_next;
    end
    if (adv3) begin
      res3 <= res3_next;
      chg3 <= chg2;
    end
  end

  assign out_valid             = valid3;
  assign out_data.result_pixel = res3;
  assign out_data.changed      = chg3;

endmodule

[hw/rtl/pixel_alpha_compositor_top.sv]
// ----------------------------------------------------------------------------
// pixel_alpha_compositor_top
// per-pixel RGBA8888 compositing unit of a 2D blitter with APB register port
// ----------------------------------------------------------------------------
// usage:
//   requests enter on in_valid/in_ready with in_data (operation, source
//   pixels, destination pixel, glyph coverage); each request yields exactly
//   one result on out_valid/out_ready with out_data (result pixel, changed).
//   a request passes three register stages (source select, channel
//   multipliers, divide by 255 with final select) before out_valid; one
//   request is taken every cycle while the receiver keeps taking results
//   or a stage is still empty.
//   when the receiver stalls, results stay in the output register and the
//   stages behind it fill; in_ready falls only once all three are full.
//   registers: 0x0 text_color, 0x4 swap_match_color, 0x8 swap_new_color,
//   written over APB, by the user only while no request is in flight;
//   the block itself has no check for this. reset empties the pipeline
//   and loads text_color with white and both swap colors with zero.
// ----------------------------------------------------------------------------
module pixel_alpha_compositor_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pac_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pac_pkg::req_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pac_pkg::rsp_t              out_data
);

  pac_pkg::cfg_t cfg;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_color       <= pac_pkg::TEXT_COLOR_RST;
      cfg.swap_match_color <= 32'd0;
      cfg.swap_new_color   <= 32'd0;
    end else if (wr_en) begin
      case (reg_idx)
        pac_pkg::REG_TEXT_COLOR: cfg.text_color       <= pwdata[23:0];
        pac_pkg::REG_SWAP_MATCH: cfg.swap_match_color <= pwdata;
        pac_pkg::REG_SWAP_NEW:   cfg.swap_new_color   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pac_pkg::REG_TEXT_COLOR: prdata = {8'd0, cfg.text_color};
      pac_pkg::REG_SWAP_MATCH: prdata = cfg.swap_match_color;
      pac_pkg::REG_SWAP_NEW:   prdata = cfg.swap_new_color;
      default:                 prdata = 32'd0;
    endcase
  end

  pac_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // an accepting receiver never backs up the request side
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("request stalled while output can move");

  // a write to the new swap color lands in its register
  a_write_reg: assert property (@(posedge clk) disable iff (rst)
    (wr_en && reg_idx == pac_pkg::REG_SWAP_NEW) |=> (cfg.swap_new_color == $past(pwdata)))
    else $error("swap color register not written");
`endif

endmodule

[bench/pac_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pac_result_checker
// watches the register port and both request and result channels of the
// pixel alpha compositor, keeps its own copy of the color registers, predicts
// the pixel for every accepted request and compares it with the results in
// order; hands the mismatch count and the number of pending pixels upward
// ----------------------------------------------------------------------------
module pac_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [pac_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  pac_pkg::req_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  pac_pkg::rsp_t              out_data,
  output int unsigned                mismatches,
  output int unsigned                in_flight
);

  pac_pkg::cfg_t colors;
  pac_pkg::rsp_t expected_pixels[$];
  pac_pkg::rsp_t want;
  int unsigned   bad_count;

  function automatic logic [31:0] blend_over(input logic [31:0] s, input logic [31:0] d);
    int unsigned alpha;
    int unsigned inv;
    int unsigned sc;
    int unsigned dc;
    logic [31:0] mixed;
    alpha = 32'(s[31:24]);
    if (alpha == 0) return d;
    if (alpha == 32'(pac_pkg::CH_MAX)) return s;
    inv = 32'(pac_pkg::CH_MAX) - alpha;
    mixed = {pac_pkg::CH_MAX, 24'h0};
    for (int sh = 0; sh < 24; sh += 8) begin
      sc = 32'(s[sh +: 8]);
      dc = 32'(d[sh +: 8]);
      mixed[sh +: 8] = 8'((sc * alpha + dc * inv) / 32'(pac_pkg::CH_MAX));
    end
    return mixed;
  endfunction

  function automatic logic [31:0] mean_pixel(input logic [31:0] p, input logic [31:0] q);
    logic [8:0]  sum;
    logic [31:0] m;
    for (int sh = 0; sh < 32; sh += 8) begin
      sum = {1'b0, p[sh +: 8]} + {1'b0, q[sh +: 8]};
      m[sh +: 8] = sum[8:1];
    end
    return m;
  endfunction

  function automatic pac_pkg::rsp_t composite_pixel(input pac_pkg::req_t r,
                                                    input pac_pkg::cfg_t c);
    pac_pkg::rsp_t o;
    o.result_pixel = r.dst_pixel;
    o.changed      = 1'b1;
    case (r.operation)
      pac_pkg::OP_BLEND:     o.result_pixel = blend_over(r.src_pixel, r.dst_pixel);
      pac_pkg::OP_COPY:      o.result_pixel = r.src_pixel;
      pac_pkg::OP_INV_BLEND: o.result_pixel = blend_over({r.src_pixel[31:24],
                                                          ~r.src_pixel[23:0]}, r.dst_pixel);
      pac_pkg::OP_AVG_BLEND: o.result_pixel = blend_over(mean_pixel(r.src_pixel,
                                                                    r.src_pixel_second),
                                                         r.dst_pixel);
      pac_pkg::OP_AVG_COPY:  o.result_pixel = mean_pixel(r.src_pixel, r.src_pixel_second);
      pac_pkg::OP_GLYPH: begin
        if (r.coverage == 8'h00) o.changed = 1'b0;
        else o.result_pixel = blend_over({r.coverage, c.text_color}, r.dst_pixel);
      end
      pac_pkg::OP_SWAP: begin
        if (r.dst_pixel == c.swap_match_color) o.result_pixel = c.swap_new_color;
        else o.changed = 1'b0;
      end
      default: o.changed = 1'b0;
    endcase
    return o;
  endfunction

  initial begin
    mismatches = 0;
    in_flight  = 0;
    bad_count  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      colors.text_color       = pac_pkg::TEXT_COLOR_RST;
      colors.swap_match_color = '0;
      colors.swap_new_color   = '0;
      expected_pixels.delete();
    end else begin
      if (in_valid && in_ready) expected_pixels.push_back(composite_pixel(in_data, colors));
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          pac_pkg::REG_TEXT_COLOR: colors.text_color       = pwdata[23:0];
          pac_pkg::REG_SWAP_MATCH: colors.swap_match_color = pwdata;
          pac_pkg::REG_SWAP_NEW:   colors.swap_new_color   = pwdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected result pixel %h changed %b", $realtime,
                     out_data.result_pixel, out_data.changed);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.result_pixel !== want.result_pixel || out_data.changed !== want.changed) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: pixel mismatch: expected %h changed %b, got %h changed %b",
                       $realtime, want.result_pixel, want.changed,
                       out_data.result_pixel, out_data.changed);
          end
        end
      end
    end
    mismatches <= bad_count;
    in_flight  <= expected_pixels.size();
  end

endmodule

[bench/tb_pixel_alpha_compositor_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_alpha_compositor_top
// drives pixel requests and register writes into the compositor: a directed
// set of corner pixels for every operation, then phases of random requests
// under several color settings with random request gaps and result stalls,
// one long result hold-off that backs up the pipeline, and drains between
// phases; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_pixel_alpha_compositor_top;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [pac_pkg::ADDR_W-1:0] paddr     = '0;
  logic [31:0]                pwdata    = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  pac_pkg::req_t              in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  pac_pkg::rsp_t              out_data;
  int unsigned                mismatches;
  int unsigned                in_flight;

  logic                       src_idle_en = 1'b1;
  logic                       snk_stall_en = 1'b1;
  int unsigned                hold_left = 0;
  int unsigned                stall_left = 0;
  logic [31:0]                match_color = '0;

  pixel_alpha_compositor_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pac_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(4_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // result side: per-result stall, long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(negedge clk);
      if (out_valid && out_ready) stall_left = snk_stall_en ? $urandom_range(0, 3) : 0;
    end
  end

  function automatic pac_pkg::req_t pixel_request(input logic [2:0] op,
                                                  input logic [31:0] s1,
                                                  input logic [31:0] s2,
                                                  input logic [31:0] d,
                                                  input logic [7:0] cov);
    pac_pkg::req_t r;
    r.operation        = op;
    r.src_pixel        = s1;
    r.src_pixel_second = s2;
    r.dst_pixel        = d;
    r.coverage         = cov;
    return r;
  endfunction

  function automatic pac_pkg::req_t random_request(input logic [31:0] match);
    pac_pkg::req_t r;
    int unsigned   pick;
    r.src_pixel        = $urandom;
    r.src_pixel_second = $urandom;
    r.dst_pixel        = $urandom;
    r.coverage         = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 3) r.operation = OP_UNUSED;
    else r.operation = 3'($urandom_range(pac_pkg::OP_BLEND, pac_pkg::OP_SWAP));
    pick = $urandom_range(0, 9);
    if (pick == 0) r.src_pixel[31:24] = 8'h00;
    else if (pick == 1) r.src_pixel[31:24] = 8'hFF;
    if ($urandom_range(0, 7) == 0) r.src_pixel_second[31:24] = r.src_pixel[31:24];
    pick = $urandom_range(0, 9);
    if (pick == 0) r.coverage = 8'h00;
    else if (pick == 1) r.coverage = 8'hFF;
    if (r.operation == pac_pkg::OP_SWAP && $urandom_range(0, 1) == 1) r.dst_pixel = match;
    return r;
  endfunction

  task automatic send_request(input pac_pkg::req_t r);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == pac_pkg::REG_SWAP_MATCH) match_color = value;
  endtask

  initial begin
    logic saved_idle;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed corners, reset colors
    send_request(pixel_request(pac_pkg::OP_BLEND, 32'h0012_3456, 32'h0, 32'hA5A5_A5A5,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_BLEND, 32'hFFAB_CDEF, 32'h0, 32'h1234_5678,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_BLEND, 32'h8000_FF00, 32'h0, 32'h00FF_00FF,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_BLEND, 32'h01FF_FFFF, 32'h0, 32'h0000_0000,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_BLEND, 32'hFE00_0000, 32'h0, 32'hFFFF_FFFF,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_COPY, 32'h0000_0000, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 8'hFF));
    send_request(pixel_request(pac_pkg::OP_COPY, 32'hFFFF_FFFF, 32'h0, 32'h0000_0000,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_INV_BLEND, 32'h0012_3456, 32'h0, 32'h5A5A_5A5A,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_INV_BLEND, 32'hFF00_0000, 32'h0, 32'h0000_0000,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_INV_BLEND, 32'h7F80_40C0, 32'h0, 32'hC040_8020,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_AVG_BLEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_AVG_BLEND, 32'hFFFF_FFFF, 32'h0000_0000,
                               32'h1234_5678, 8'h00));
    send_request(pixel_request(pac_pkg::OP_AVG_BLEND, 32'h0011_2233, 32'h0144_5566,
                               32'h89AB_CDEF, 8'h00));
    send_request(pixel_request(pac_pkg::OP_AVG_COPY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_AVG_COPY, 32'h0101_0101, 32'h0000_0000,
                               32'hFFFF_FFFF, 8'h00));
    send_request(pixel_request(pac_pkg::OP_GLYPH, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_GLYPH, 32'h0, 32'h0, 32'h1234_5678, 8'hFF));
    send_request(pixel_request(pac_pkg::OP_GLYPH, 32'h0, 32'h0, 32'h0000_0000, 8'h40));
    send_request(pixel_request(pac_pkg::OP_SWAP, 32'hFFFF_FFFF, 32'h0, 32'h0000_0000,
                               8'h00));
    send_request(pixel_request(pac_pkg::OP_SWAP, 32'h0, 32'h0, 32'h0000_0001, 8'h00));
    send_request(pixel_request(OP_UNUSED, 32'h0, 32'h0, 32'hDEAD_BEEF, 8'h00));
    send_request(pixel_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               8'hFF));

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if (phase == 0) begin
        write_reg(pac_pkg::REG_TEXT_COLOR, 32'h0000_0000);
        write_reg(pac_pkg::REG_SWAP_MATCH, 32'hFFFF_FFFF);
        write_reg(pac_pkg::REG_SWAP_NEW, 32'h0000_0000);
      end else if (phase == 1) begin
        write_reg(pac_pkg::REG_TEXT_COLOR, 32'hFFFF_FFFF);
        write_reg(pac_pkg::REG_SWAP_MATCH, 32'h0000_0000);
        write_reg(pac_pkg::REG_SWAP_NEW, 32'hFFFF_FFFF);
      end else begin
        write_reg(pac_pkg::REG_TEXT_COLOR, $urandom);
        write_reg(pac_pkg::REG_SWAP_MATCH, $urandom);
        write_reg(pac_pkg::REG_SWAP_NEW, $urandom);
      end
      src_idle_en  = (phase != 1 && phase != 4);
      snk_stall_en = (phase != 2 && phase != 4);

      // back up the pipeline behind a long result hold-off
      if (phase == 3) begin
        @(negedge clk);
        hold_left = 60;
        @(posedge clk);
        saved_idle  = src_idle_en;
        src_idle_en = 1'b0;
        repeat (20) send_request(random_request(match_color));
        src_idle_en = saved_idle;
      end

      repeat (255) send_request(random_request(match_color));
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
